FILE: src/tcp_active_open_engine_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the TCP active open engine
// Shorthand for clocked concurrent assertions, with and without reset gating.
// ---------------------------------------------------------------------------
`ifndef TCP_ACTIVE_OPEN_ENGINE_ASSERT_SVH
`define TCP_ACTIVE_OPEN_ENGINE_ASSERT_SVH

// checked only while out of reset
`define TAO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tcp_active_open_engine assertion failed");

// checked at every edge
`define TAO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tcp_active_open_engine assertion failed");

`endif

FILE: src/tcpao_pkg.sv
// ---------------------------------------------------------------------------
// TCP active open engine package
// Payload types, command record, register map and checksum helper.
// ---------------------------------------------------------------------------
package tcpao_pkg;

  typedef struct packed {
    logic        kind;
    logic [15:0] ether_type;
    logic [15:0] arp_opcode;
    logic [47:0] reply_mac;
    logic [31:0] source_ip;
    logic [7:0]  seg_flags;
    logic [31:0] peer_seq;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
    logic [1:0] phase;
  } out_item_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [31:0] peer_ip;
    logic [31:0] initial_seq;
    logic [15:0] own_port;
    logic [15:0] peer_port;
    logic [15:0] window_size;
    logic [7:0]  time_to_live;
  } cfg_t;

  typedef struct packed {
    logic        is_arp;
    logic [1:0]  phase;
    logic [47:0] mac;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [7:0]  flags;
  } cmd_t;

  typedef enum logic [2:0] {
    REG_OWN_MAC     = 3'd0,
    REG_OWN_IP      = 3'd1,
    REG_PEER_IP     = 3'd2,
    REG_INITIAL_SEQ = 3'd3,
    REG_OWN_PORT    = 3'd4,
    REG_PEER_PORT   = 3'd5,
    REG_WINDOW_SIZE = 3'd6,
    REG_TTL         = 3'd7
  } reg_idx_e;

  localparam logic [1:0]  PH_IDLE    = 2'd0;
  localparam logic [1:0]  PH_ARP     = 2'd1;
  localparam logic [1:0]  PH_SYNACK  = 2'd2;
  localparam logic [1:0]  PH_ESTAB   = 2'd3;

  localparam logic [15:0] ETH_ARP    = 16'h0806;
  localparam logic [15:0] ETH_IPV4   = 16'h0800;
  localparam logic [15:0] ARP_REPLY  = 16'd2;
  localparam logic [7:0]  FL_SYNACK  = 8'h12;
  localparam logic [7:0]  FL_SYN     = 8'h02;
  localparam logic [7:0]  FL_ACK     = 8'h10;

  localparam logic [5:0]  ARP_LAST   = 6'd41;
  localparam logic [5:0]  TCP_LAST   = 6'd53;
  localparam int          QDEPTH     = 2;

  function automatic logic [15:0] fold_not(input logic [19:0] s);
    logic [16:0] a;
    logic [16:0] b;
    a = {13'd0, s[19:16]} + {1'b0, s[15:0]};
    b = {16'd0, a[16]} + {1'b0, a[15:0]};
    return ~b[15:0];
  endfunction

endpackage

FILE: src/tcpao_front.sv
// ---------------------------------------------------------------------------
// TCP active open front end
// Accepts items, tracks connection state and queues frame commands.
// ---------------------------------------------------------------------------
module tcpao_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tcpao_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tcpao_pkg::in_item_t in_i,
  output logic               push_o,
  input  logic               q_ready_i,
  output tcpao_pkg::cmd_t     cmd_o
);
  import tcpao_pkg::*;

  logic [1:0]  phase_q, phase_d;
  logic [31:0] seq_q, seq_d;
  logic [47:0] mac_q, mac_d;
  logic        arp_hit, syn_hit, acc;

  assign in_ready_o = q_ready_i;
  assign acc = in_valid_i && q_ready_i;

  always_comb begin
    arp_hit = (phase_q == PH_ARP) && (in_i.ether_type == ETH_ARP) &&
              (in_i.arp_opcode == ARP_REPLY);
    syn_hit = (phase_q == PH_SYNACK) && (in_i.ether_type == ETH_IPV4) &&
              (in_i.source_ip == cfg_i.peer_ip) && (in_i.seg_flags == FL_SYNACK);
    phase_d = phase_q;
    seq_d   = seq_q;
    mac_d   = mac_q;
    push_o  = 1'b0;
    cmd_o   = '0;
    if (!in_i.kind) begin
      push_o       = acc;
      cmd_o.is_arp = 1'b1;
      cmd_o.phase  = PH_ARP;
      if (acc) begin
        phase_d = PH_ARP;
        seq_d   = cfg_i.initial_seq;
      end
    end else if (arp_hit) begin
      push_o      = acc;
      cmd_o.phase = PH_SYNACK;
      cmd_o.mac   = in_i.reply_mac;
      cmd_o.seq   = seq_q;
      cmd_o.flags = FL_SYN;
      if (acc) begin
        phase_d = PH_SYNACK;
        mac_d   = in_i.reply_mac;
      end
    end else if (syn_hit) begin
      push_o      = acc;
      cmd_o.phase = PH_ESTAB;
      cmd_o.mac   = mac_q;
      cmd_o.seq   = seq_q + 32'd1;
      cmd_o.ack   = in_i.peer_seq + 32'd1;
      cmd_o.flags = FL_ACK;
      if (acc) begin
        phase_d = PH_ESTAB;
        seq_d   = seq_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seq_q   <= '0;
      mac_q   <= '0;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      mac_q   <= mac_d;
    end
  end

endmodule

FILE: src/tcpao_fifo.sv
// ---------------------------------------------------------------------------
// TCP active open command queue
// Small FIFO between the front end and the frame builder.
// ---------------------------------------------------------------------------
module tcpao_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           ready_o,
  input  tcpao_pkg::cmd_t data_i,
  output logic           valid_o,
  input  logic           pop_i,
  output tcpao_pkg::cmd_t data_o
);
  import tcpao_pkg::*;

  localparam int PW = $clog2(QDEPTH);

  cmd_t          mem_q [QDEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign ready_o = (cnt_q != (PW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + PW'(1);
      end
      if (pop_i) begin
        rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + PW'(1);
      end
      cnt_q <= cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

FILE: src/tcpao_back.sv
// ---------------------------------------------------------------------------
// TCP active open frame builder
// Computes checksums and streams ARP or TCP frames one byte per beat.
// ---------------------------------------------------------------------------
module tcpao_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tcpao_pkg::cfg_t      cfg_i,
  input  logic                q_valid_i,
  input  tcpao_pkg::cmd_t      cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcpao_pkg::out_item_t out_o
);
  import tcpao_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SUM, S_FOLD, S_SEND} state_e;

  state_e      state_q;
  cmd_t        cur_q;
  logic [5:0]  idx_q;
  logic [19:0] addr_q, hdr_q, num_q;
  logic [15:0] ipck_q, tcpck_q;
  logic        ov_q;
  out_item_t   out_q;
  logic [431:0] frame;
  logic [5:0]  sel, last_idx;
  logic        take;

  assign out_valid_o = ov_q;
  assign out_o       = out_q;
  assign pop_o       = (state_q == S_IDLE) && q_valid_i;
  assign take        = !ov_q || out_ready_i;
  assign last_idx    = cur_q.is_arp ? ARP_LAST : TCP_LAST;
  assign sel         = TCP_LAST - idx_q;

  always_comb begin
    if (cur_q.is_arp) begin
      frame = {48'hFFFF_FFFF_FFFF, cfg_i.own_mac, ETH_ARP, 16'd1, ETH_IPV4,
               8'd6, 8'd4, 16'd1, cfg_i.own_mac, cfg_i.own_ip, 48'd0,
               cfg_i.peer_ip, 96'd0};
    end else begin
      frame = {cur_q.mac, cfg_i.own_mac, ETH_IPV4, 8'h45, 8'h00, 16'd40,
               32'd0, cfg_i.time_to_live, 8'd6, ipck_q, cfg_i.own_ip,
               cfg_i.peer_ip, cfg_i.own_port, cfg_i.peer_port, cur_q.seq,
               cur_q.ack, 8'h50, cur_q.flags, cfg_i.window_size, tcpck_q, 16'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= cmd_i;
    end
    if (state_q == S_SUM) begin
      addr_q <= 20'(cfg_i.own_ip[31:16]) + 20'(cfg_i.own_ip[15:0]) +
                20'(cfg_i.peer_ip[31:16]) + 20'(cfg_i.peer_ip[15:0]);
      hdr_q  <= 20'(cfg_i.own_port) + 20'(cfg_i.peer_port) +
                20'(cfg_i.window_size) + 20'({8'h50, cur_q.flags}) + 20'd26;
      num_q  <= 20'(cur_q.seq[31:16]) + 20'(cur_q.seq[15:0]) +
                20'(cur_q.ack[31:16]) + 20'(cur_q.ack[15:0]);
    end
    if (state_q == S_FOLD) begin
      ipck_q  <= fold_not(addr_q + 20'h4500 + 20'd40 + 20'({cfg_i.time_to_live, 8'd6}));
      tcpck_q <= fold_not(addr_q + hdr_q + num_q);
    end
    if ((state_q == S_SEND) && take) begin
      out_q.frame_byte <= frame[{sel, 3'b000} +: 8];
      out_q.last_byte  <= (idx_q == last_idx);
      out_q.phase      <= cur_q.phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      ov_q <= ((state_q == S_SEND) && take) || (ov_q && !out_ready_i);
      case (state_q)
        S_IDLE: begin
          idx_q <= '0;
          if (q_valid_i) begin
            state_q <= S_SUM;
          end
        end
        S_SUM:  state_q <= S_FOLD;
        S_FOLD: state_q <= S_SEND;
        S_SEND: begin
          if (take) begin
            idx_q <= idx_q + 6'd1;
            if (idx_q == last_idx) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/tcp_active_open_engine.sv
// ---------------------------------------------------------------------------
// TCP active open engine
// Client side TCP open with ARP resolution; emits frames one byte per beat.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | in_i   (in_item_t)
//  out     | out_valid/out_ready| out_o  (out_item_t)
//  cfg     | psel/penable/pwrite| paddr, pwdata, prdata (64 bit)
//
//  A frame is prepared by load, partial sums and checksum fold; the byte
//  serializer then sends its 42 (ARP) or 54 (TCP) bytes and loads no new
//  frame before the last is issued. Items that emit nothing push no command.
//  A two-entry command queue lets the front end keep accepting while the
//  serializer is stalled. Reset clears phase, sequence and peer MAC.
module tcp_active_open_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tcpao_pkg::in_item_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tcpao_pkg::out_item_t out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import tcpao_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e widx;
  logic     push, q_ready, q_valid, pop;
  cmd_t     cmd_in, cmd_out;

  assign pready = 1'b1;
  assign widx   = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_mac      <= '0;
      cfg_q.own_ip       <= '0;
      cfg_q.peer_ip      <= '0;
      cfg_q.initial_seq  <= '0;
      cfg_q.own_port     <= 16'd52000;
      cfg_q.peer_port    <= 16'd80;
      cfg_q.window_size  <= 16'd14600;
      cfg_q.time_to_live <= 8'd255;
    end else if (psel && penable && pwrite) begin
      case (widx)
        REG_OWN_MAC:     cfg_q.own_mac      <= pwdata[47:0];
        REG_OWN_IP:      cfg_q.own_ip       <= pwdata[31:0];
        REG_PEER_IP:     cfg_q.peer_ip      <= pwdata[31:0];
        REG_INITIAL_SEQ: cfg_q.initial_seq  <= pwdata[31:0];
        REG_OWN_PORT:    cfg_q.own_port     <= pwdata[15:0];
        REG_PEER_PORT:   cfg_q.peer_port    <= pwdata[15:0];
        REG_WINDOW_SIZE: cfg_q.window_size  <= pwdata[15:0];
        REG_TTL:         cfg_q.time_to_live <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_OWN_MAC:     prdata = {16'd0, cfg_q.own_mac};
      REG_OWN_IP:      prdata = {32'd0, cfg_q.own_ip};
      REG_PEER_IP:     prdata = {32'd0, cfg_q.peer_ip};
      REG_INITIAL_SEQ: prdata = {32'd0, cfg_q.initial_seq};
      REG_OWN_PORT:    prdata = {48'd0, cfg_q.own_port};
      REG_PEER_PORT:   prdata = {48'd0, cfg_q.peer_port};
      REG_WINDOW_SIZE: prdata = {48'd0, cfg_q.window_size};
      REG_TTL:         prdata = {56'd0, cfg_q.time_to_live};
      default:         prdata = '0;
    endcase
  end

  tcpao_front u_front (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .in_valid_i, .in_ready_o, .in_i,
    .push_o(push), .q_ready_i(q_ready), .cmd_o(cmd_in)
  );

  tcpao_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .ready_o(q_ready), .data_i(cmd_in),
    .valid_o(q_valid), .pop_i(pop), .data_o(cmd_out)
  );

  tcpao_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(q_valid), .cmd_i(cmd_out),
    .pop_o(pop), .out_valid_o, .out_ready_i, .out_o
  );

`include "tcp_active_open_engine_assert.svh"

  `TAO_ASSERT(a_phase_set, out_valid_o |-> (out_o.phase != PH_IDLE))
  `TAO_ASSERT(a_no_double_last,
    (out_valid_o && out_ready_i && out_o.last_byte) |=> !(out_valid_o && out_o.last_byte))
  `TAO_ASSERT_ALWAYS(a_pready, pready)

endmodule

FILE: test/tcp_active_open_engine_test.sv
// ---------------------------------------------------------------------------
// TCP active open engine testbench
// Drives start and received-frame beats, writes the registers over APB while
// the engine is idle, predicts every transmitted byte and compares in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcp_active_open_engine_test;
  import tcpao_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  in_item_t    in_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  tcp_active_open_engine uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_i, .out_valid_o, .out_ready_i,
    .out_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of registers and connection state
  cfg_t        cfg;
  logic [1:0]  conn_ph;
  logic [47:0] peer_mac;
  logic [31:0] seq_now;
  out_item_t   byte_queue[$];
  logic [7:0]  frame[54];

  int  errors = 0;
  int  idle_cycles = 0;
  int  rx_gap = 0;
  bit  rx_bursts = 1'b1;
  bit  rx_hold = 1'b0;
  bit  tx_bursts = 1'b1;

  function automatic logic [15:0] csum_fold(input logic [31:0] s);
    s = {16'd0, s[31:16]} + {16'd0, s[15:0]};
    s = s + {16'd0, s[31:16]};
    return ~s[15:0];
  endfunction

  function automatic logic [31:0] frame_words(input int from);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i < 20; i += 2) s += {frame[from + i], frame[from + i + 1]};
    return s;
  endfunction

  task automatic put_bytes(input int at, input int n, input logic [63:0] v);
    for (int i = 0; i < n; i++) frame[at + i] = v[8 * (n - 1 - i) +: 8];
  endtask

  task automatic queue_frame(input int n);
    out_item_t o;
    for (int k = 0; k < n; k++) begin
      o.frame_byte = frame[k];
      o.last_byte = (k == n - 1);
      o.phase = conn_ph;
      byte_queue.push_back(o);
    end
  endtask

  task automatic build_segment(input logic [31:0] sq, input logic [31:0] an,
                               input logic [7:0] fl);
    logic [31:0] ps;
    put_bytes(0, 6, peer_mac);
    put_bytes(6, 6, cfg.own_mac);
    put_bytes(12, 2, ETH_IPV4);
    put_bytes(14, 4, 32'h4500_0028);
    put_bytes(18, 4, 0);
    frame[22] = cfg.time_to_live;
    frame[23] = 8'd6;
    put_bytes(24, 2, 0);
    put_bytes(26, 4, cfg.own_ip);
    put_bytes(30, 4, cfg.peer_ip);
    put_bytes(24, 2, csum_fold(frame_words(14)));
    put_bytes(34, 2, cfg.own_port);
    put_bytes(36, 2, cfg.peer_port);
    put_bytes(38, 4, sq);
    put_bytes(42, 4, an);
    frame[46] = 8'h50;
    frame[47] = fl;
    put_bytes(48, 2, cfg.window_size);
    put_bytes(50, 4, 0);
    ps = cfg.own_ip[31:16] + cfg.own_ip[15:0] + cfg.peer_ip[31:16] + cfg.peer_ip[15:0] + 26;
    put_bytes(50, 2, csum_fold(ps + frame_words(34)));
  endtask

  task automatic predict_open(input in_item_t it);
    if (!it.kind) begin
      seq_now = cfg.initial_seq;
      conn_ph = PH_ARP;
      put_bytes(0, 6, 48'hFFFF_FFFF_FFFF);
      put_bytes(6, 6, cfg.own_mac);
      put_bytes(12, 2, ETH_ARP);
      put_bytes(14, 2, 16'd1);
      put_bytes(16, 2, ETH_IPV4);
      frame[18] = 8'd6;
      frame[19] = 8'd4;
      put_bytes(20, 2, 16'd1);
      put_bytes(22, 6, cfg.own_mac);
      put_bytes(28, 4, cfg.own_ip);
      put_bytes(32, 6, 0);
      put_bytes(38, 4, cfg.peer_ip);
      queue_frame(42);
    end else if (conn_ph == PH_ARP && it.ether_type == ETH_ARP && it.arp_opcode == ARP_REPLY) begin
      peer_mac = it.reply_mac;
      conn_ph = PH_SYNACK;
      build_segment(seq_now, 0, FL_SYN);
      queue_frame(54);
    end else if (conn_ph == PH_SYNACK && it.ether_type == ETH_IPV4 &&
                 it.source_ip == cfg.peer_ip && it.seg_flags == FL_SYNACK) begin
      seq_now = seq_now + 1;
      conn_ph = PH_ESTAB;
      build_segment(seq_now, it.peer_seq + 1, FL_ACK);
      queue_frame(54);
    end
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [63:0] v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 3'd0};
    pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_OWN_MAC:     cfg.own_mac = v[47:0];
      REG_OWN_IP:      cfg.own_ip = v[31:0];
      REG_PEER_IP:     cfg.peer_ip = v[31:0];
      REG_INITIAL_SEQ: cfg.initial_seq = v[31:0];
      REG_OWN_PORT:    cfg.own_port = v[15:0];
      REG_PEER_PORT:   cfg.peer_port = v[15:0];
      REG_WINDOW_SIZE: cfg.window_size = v[15:0];
      default:         cfg.time_to_live = v[7:0];
    endcase
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (byte_queue.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
  endtask

  task automatic send_beat(input in_item_t it);
    if (tx_bursts && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_open(it);
    @(negedge clk_i);
  endtask

  function automatic in_item_t rand_beat();
    in_item_t it;
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    case ($urandom_range(9))
      0: it.kind = 1'b0;
      1, 2, 3: begin
        it.kind = 1'b1;
        it.ether_type = ETH_ARP;
        it.arp_opcode = ($urandom_range(4) == 0) ? 16'(it.arp_opcode) : ARP_REPLY;
      end
      4, 5, 6: begin
        it.kind = 1'b1;
        it.ether_type = ETH_IPV4;
        if ($urandom_range(4) != 0) it.source_ip = cfg.peer_ip;
        if ($urandom_range(4) != 0) it.seg_flags = FL_SYNACK;
      end
      default: it.kind = 1'b1;
    endcase
    return it;
  endfunction

  function automatic in_item_t beat(input logic k, input logic [15:0] et,
                                    input logic [15:0] op, input logic [31:0] sip,
                                    input logic [7:0] fl, input logic [31:0] ps,
                                    input logic [47:0] mac);
    beat = '{kind: k, ether_type: et, arp_opcode: op, reply_mac: mac,
             source_ip: sip, seg_flags: fl, peer_seq: ps};
  endfunction

  // receiver: random stall bursts, plus a forced hold-off
  always @(negedge clk_i) begin
    if (rx_hold) begin
      out_ready_i <= 1'b0;
    end else if (rx_bursts && rx_gap > 0) begin
      out_ready_i <= 1'b0;
      rx_gap--;
    end else if (rx_bursts && $urandom_range(7) == 0) begin
      out_ready_i <= 1'b0;
      rx_gap = $urandom_range(0, 14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_b;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (byte_queue.size() == 0) begin
        $error("unexpected byte %h", out_o.frame_byte);
        errors++;
      end else begin
        exp_b = byte_queue.pop_front();
        if (out_o.frame_byte !== exp_b.frame_byte) begin
          $error("frame_byte exp %h got %h", exp_b.frame_byte, out_o.frame_byte);
          errors++;
        end
        if (out_o.last_byte !== exp_b.last_byte) begin
          $error("last_byte exp %b got %b", exp_b.last_byte, out_o.last_byte);
          errors++;
        end
        if (out_o.phase !== exp_b.phase) begin
          $error("phase exp %0d got %0d", exp_b.phase, out_o.phase);
          errors++;
        end
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tcp_active_open_engine_test: errors");
      $finish;
    end
  end

  initial begin
    in_item_t directed[$];
    in_item_t it;
    cfg = '{own_mac: 0, own_ip: 0, peer_ip: 0, initial_seq: 0, own_port: 16'd52000,
            peer_port: 16'd80, window_size: 16'd14600, time_to_live: 8'd255};
    conn_ph = PH_IDLE;
    peer_mac = 0;
    seq_now = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset values: SYN-ACK before any start is ignored, then a full open
    directed = '{
      beat(1, ETH_IPV4, 0, 0, FL_SYNACK, 5, 0),
      beat(1, ETH_ARP, ARP_REPLY, 0, 0, 0, 48'h1),
      beat(0, 0, 0, 0, 0, 0, 0),
      beat(1, ETH_IPV4, 0, 0, FL_SYNACK, 0, 0),
      beat(1, ETH_ARP, 16'd1, 0, 0, 0, 48'h1),
      beat(1, 16'h0805, ARP_REPLY, 0, 0, 0, 48'h1),
      beat(1, ETH_ARP, ARP_REPLY, 32'hFFFF_FFFF, 8'hFF, 0, 48'hFFFF_FFFF_FFFF),
      beat(1, ETH_ARP, ARP_REPLY, 0, 0, 0, 48'h5),
      beat(1, ETH_IPV4, 0, 32'h1, FL_SYNACK, 0, 0),
      beat(1, ETH_IPV4, 0, 0, 8'h13, 0, 0),
      beat(1, ETH_IPV4, 0, 0, FL_SYNACK, 32'hFFFF_FFFF, 0),
      beat(1, ETH_IPV4, 0, 0, FL_SYNACK, 32'h1234, 0),
      beat(0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF)
    };
    foreach (directed[i]) send_beat(directed[i]);
    drain();

    // extremes: all-ones registers, sequence wrap
    reg_write(REG_OWN_MAC, 64'hFFFF_FFFF_FFFF);
    reg_write(REG_OWN_IP, 64'hFFFF_FFFF);
    reg_write(REG_PEER_IP, 64'hFFFF_FFFF);
    reg_write(REG_INITIAL_SEQ, 64'hFFFF_FFFF);
    reg_write(REG_OWN_PORT, 64'hFFFF);
    reg_write(REG_PEER_PORT, 64'hFFFF);
    reg_write(REG_WINDOW_SIZE, 64'hFFFF);
    reg_write(REG_TTL, 64'hFF);
    send_beat(beat(0, 0, 0, 0, 0, 0, 0));
    send_beat(beat(1, ETH_ARP, ARP_REPLY, 0, 0, 0, 48'hFFFF_FFFF_FFFF));
    send_beat(beat(1, ETH_IPV4, 0, 32'hFFFF_FFFF, FL_SYNACK, 32'hFFFF_FFFF, 0));
    drain();

    // all registers zero
    reg_write(REG_OWN_MAC, 0);
    reg_write(REG_OWN_IP, 0);
    reg_write(REG_PEER_IP, 0);
    reg_write(REG_INITIAL_SEQ, 0);
    reg_write(REG_OWN_PORT, 0);
    reg_write(REG_PEER_PORT, 0);
    reg_write(REG_WINDOW_SIZE, 0);
    reg_write(REG_TTL, 0);
    send_beat(beat(0, 0, 0, 0, 0, 0, 0));
    send_beat(beat(1, ETH_ARP, ARP_REPLY, 0, 0, 0, 48'h0));
    send_beat(beat(1, ETH_IPV4, 0, 0, FL_SYNACK, 32'h0, 0));
    drain();

    // random phases with random settings
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(REG_OWN_MAC, {$urandom, $urandom});
      reg_write(REG_OWN_IP, $urandom);
      reg_write(REG_PEER_IP, $urandom);
      reg_write(REG_INITIAL_SEQ, $urandom);
      reg_write(REG_OWN_PORT, $urandom);
      reg_write(REG_PEER_PORT, $urandom);
      reg_write(REG_WINDOW_SIZE, $urandom);
      reg_write(REG_TTL, $urandom);
      if (ph == 1) begin
        // long receiver hold-off while starts keep coming
        rx_hold = 1'b1;
        fork
          begin
            repeat (400) @(negedge clk_i);
            rx_hold = 1'b0;
          end
          begin
            for (int i = 0; i < 4; i++) send_beat(beat(0, 0, 0, 0, 0, 0, 0));
            in_valid_i <= 1'b0;
          end
        join
      end
      if (ph == 3) begin
        rx_bursts = 1'b0;
        tx_bursts = 1'b0;
      end
      for (int i = 0; i < 20; i++) begin
        it = rand_beat();
        send_beat(it);
      end
      drain();
    end

    if (errors == 0) $display("tcp_active_open_engine_test: clean");
    else $display("tcp_active_open_engine_test: errors");
    $finish;
  end

endmodule
